// ===== hw/rtl/owd_pkg.sv =====
// ----------------------------------------------------------------------------
// owd_pkg
// Shared types and constants for the optical wear detector.
// ----------------------------------------------------------------------------
package owd_pkg;

    localparam int SAMPLE_BITS = 18;
    localparam int COUNT_BITS  = 10;
    localparam int TOTAL_BITS  = SAMPLE_BITS + COUNT_BITS;
    localparam int RUN_BITS    = 4;
    localparam int ADDR_BITS   = 5;
    localparam int APB_BITS    = 32;
    localparam int IN_BITS     = ((2 * SAMPLE_BITS + 7) / 8) * 8;
    localparam int OUT_USED    = 4 * SAMPLE_BITS + 2;
    localparam int OUT_BITS    = ((OUT_USED + 7) / 8) * 8;

    localparam logic [COUNT_BITS-1:0] WINDOW_RESET  = COUNT_BITS'(100);
    localparam logic [RUN_BITS-1:0]   CONFIRM_RESET = RUN_BITS'(3);
    localparam logic [RUN_BITS-1:0]   RELEASE_RESET = RUN_BITS'(2);

    localparam logic [2:0] REG_IR_THR  = 3'd0;
    localparam logic [2:0] REG_RED_THR = 3'd1;
    localparam logic [2:0] REG_WINDOW  = 3'd2;
    localparam logic [2:0] REG_CONFIRM = 3'd3;
    localparam logic [2:0] REG_RELEASE = 3'd4;

    typedef enum logic [1:0] {
        PHASE_UNCAL    = 2'd0,
        PHASE_NOT_WORN = 2'd1,
        PHASE_WORN     = 2'd2
    } t_phase;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] ir_mean_threshold;
        logic [SAMPLE_BITS-1:0] red_mean_threshold;
        logic [COUNT_BITS-1:0]  window_length;
        logic [RUN_BITS-1:0]    confirm_windows;
        logic [RUN_BITS-1:0]    release_windows;
    } t_cfg;

    typedef struct packed {
        logic                  start;
        logic [TOTAL_BITS-1:0] dividend;
        logic [COUNT_BITS-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic                   done;
        logic [SAMPLE_BITS-1:0] quotient;
    } t_div_rsp;

endpackage

// ===== hw/rtl/owd_div.sv =====
// ----------------------------------------------------------------------------
// owd_div
// Radix-2 restoring divider, one quotient bit per cycle, shared by both channels.
// ----------------------------------------------------------------------------
module owd_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  owd_pkg::t_div_req i_req,
    output owd_pkg::t_div_rsp o_rsp
);
    import owd_pkg::*;

    localparam int STEP_BITS = $clog2(TOTAL_BITS);
    localparam logic [STEP_BITS-1:0] LAST_STEP = STEP_BITS'(TOTAL_BITS - 1);

    logic                  r_busy;
    logic                  r_done;
    logic [STEP_BITS-1:0]  r_step;
    logic [COUNT_BITS-1:0] r_rem;
    logic [TOTAL_BITS-1:0] r_acc;
    logic [COUNT_BITS-1:0] r_divisor;

    logic [COUNT_BITS:0]   shifted;
    logic                  fits;
    logic [COUNT_BITS:0]   diff;

    assign shifted = {r_rem, r_acc[TOTAL_BITS-1]};
    assign fits    = shifted >= {1'b0, r_divisor};
    assign diff    = shifted - {1'b0, r_divisor};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (r_step == LAST_STEP) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem     <= '0;
            r_acc     <= i_req.dividend;
            r_divisor <= i_req.divisor;
        end else if (r_busy) begin
            r_rem <= fits ? diff[COUNT_BITS-1:0] : shifted[COUNT_BITS-1:0];
            r_acc <= {r_acc[TOTAL_BITS-2:0], fits};
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_acc[SAMPLE_BITS-1:0];

endmodule

// ===== hw/rtl/owd_wear.sv =====
// ----------------------------------------------------------------------------
// owd_wear
// Wear state tracker with confirm and release run counters.
// ----------------------------------------------------------------------------
module owd_wear (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_update,
    input  logic [owd_pkg::SAMPLE_BITS-1:0] i_ir_mean,
    input  logic [owd_pkg::SAMPLE_BITS-1:0] i_red_mean,
    input  owd_pkg::t_cfg                i_cfg,
    output owd_pkg::t_phase              o_phase
);
    import owd_pkg::*;

    t_phase              r_phase, n_phase;
    logic [RUN_BITS-1:0] r_confirm, n_confirm;
    logic [RUN_BITS-1:0] r_release, n_release;
    logic [RUN_BITS-1:0] confirm_inc;
    logic [RUN_BITS-1:0] release_inc;
    logic                uncal;
    logic                worn_like;

    assign confirm_inc = r_confirm + 1'b1;
    assign release_inc = r_release + 1'b1;
    assign uncal       = (i_cfg.ir_mean_threshold == '0) || (i_cfg.red_mean_threshold == '0);
    assign worn_like   = (i_ir_mean >= i_cfg.ir_mean_threshold) &&
                         (i_red_mean >= i_cfg.red_mean_threshold);

    always_comb begin
        n_phase   = r_phase;
        n_confirm = r_confirm;
        n_release = r_release;
        if (i_update) begin
            if (uncal) begin
                n_phase   = PHASE_UNCAL;
                n_confirm = '0;
                n_release = '0;
            end else if (worn_like) begin
                n_release = '0;
                if (r_phase != PHASE_WORN) begin
                    if (confirm_inc >= i_cfg.confirm_windows) begin
                        n_phase   = PHASE_WORN;
                        n_confirm = '0;
                    end else begin
                        n_confirm = confirm_inc;
                    end
                end
            end else begin
                n_confirm = '0;
                if (r_phase == PHASE_WORN) begin
                    if (release_inc >= i_cfg.release_windows) begin
                        n_phase   = PHASE_NOT_WORN;
                        n_release = '0;
                    end else begin
                        n_release = release_inc;
                    end
                end else begin
                    n_phase   = PHASE_NOT_WORN;
                    n_release = '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PHASE_UNCAL;
            r_confirm <= '0;
            r_release <= '0;
        end else begin
            r_phase   <= n_phase;
            r_confirm <= n_confirm;
            r_release <= n_release;
        end
    end

    assign o_phase = r_phase;

endmodule

// ===== hw/rtl/optical_wear_detector.sv =====
// ----------------------------------------------------------------------------
// optical_wear_detector
// Windowed red/IR reflectance statistics and wear state detection.
// ----------------------------------------------------------------------------
// Input stream (s_axis): one red and one infrared sample per transfer.
// Samples that do not close a window are absorbed without holding the input off, so the
// input stays ready back to back. The sample that closes a window starts
// the shared divider: the IR mean, then the red mean, each divided bit by
// bit, then the wear update state and the load of the result register.
// A closing sample holds the input off until the result register is
// loaded.
// Output stream (m_axis): one transfer per closed window carrying both means,
// both swings and the wear status after the update. The result register
// lets the next window fill while a result waits; a new result that finds
// the register still full waits, with the input held off, until the
// receiver takes the old one.
// APB port: five registers at byte addresses 0, 4, 8, 12, 16; write only
// while the block is idle.
// Reset clears the window, the wear state (uncalibrated) and the result valid
// flag, and loads the register defaults.
// ----------------------------------------------------------------------------
module optical_wear_detector (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // [17:0] red_sample, [35:18] ir_sample, rest zero
    input  logic [owd_pkg::IN_BITS-1:0]   s_axis_tdata,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // [17:0] ir_mean, [35:18] ir_swing, [53:36] red_mean, [71:54] red_swing,
    // [73:72] wear_status, rest zero
    output logic [owd_pkg::OUT_BITS-1:0]  m_axis_tdata,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [owd_pkg::ADDR_BITS-1:0] paddr,
    input  logic [owd_pkg::APB_BITS-1:0]  pwdata,
    output logic [owd_pkg::APB_BITS-1:0]  prdata,
    output logic                          pready
);
    import owd_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV_IR,
        S_DIV_RED,
        S_WEAR,
        S_EMIT
    } t_state;

    t_state                 r_state;
    t_cfg                   r_cfg;
    logic                   r_div_go;
    logic                   r_out_valid;
    logic [OUT_BITS-1:0]    r_out_data;

    logic [TOTAL_BITS-1:0]  r_red_total, r_ir_total;
    logic [SAMPLE_BITS-1:0] r_red_low, r_red_high, r_ir_low, r_ir_high;
    logic [COUNT_BITS-1:0]  r_count;
    logic [SAMPLE_BITS-1:0] r_ir_mean, r_red_mean;

    logic [SAMPLE_BITS-1:0] red_in, ir_in;
    logic [COUNT_BITS-1:0]  n_count;
    logic                   closes;
    logic                   in_xfer, out_xfer, cfg_wr;
    logic [2:0]             reg_idx;
    logic [SAMPLE_BITS-1:0] quot;
    logic [SAMPLE_BITS-1:0] ir_swing, red_swing;
    logic                   load_out;

    t_div_req               div_req;
    t_div_rsp               div_rsp;
    t_phase                 phase;

    assign red_in   = s_axis_tdata[SAMPLE_BITS-1:0];
    assign ir_in    = s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
    assign n_count  = r_count + 1'b1;
    assign closes   = (n_count == '0) || (n_count >= r_cfg.window_length);
    assign in_xfer  = s_axis_tvalid && s_axis_tready;
    assign out_xfer = m_axis_tvalid && m_axis_tready;
    assign load_out = (r_state == S_EMIT) && (!r_out_valid || m_axis_tready);
    assign quot     = (r_count == '0) ? '0 : div_rsp.quotient;
    assign ir_swing  = r_ir_high - r_ir_low;
    assign red_swing = r_red_high - r_red_low;

    assign div_req.start    = r_div_go;
    assign div_req.dividend = (r_state == S_DIV_RED) ? r_red_total : r_ir_total;
    assign div_req.divisor  = r_count;

    owd_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    owd_wear u_wear (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_update   (r_state == S_WEAR),
        .i_ir_mean  (r_ir_mean),
        .i_red_mean (r_red_mean),
        .i_cfg      (r_cfg),
        .o_phase    (phase)
    );

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_div_go    <= 1'b0;
            r_out_valid <= 1'b0;
            r_count     <= '0;
            r_red_total <= '0;
            r_ir_total  <= '0;
            r_red_low   <= '1;
            r_red_high  <= '0;
            r_ir_low    <= '1;
            r_ir_high   <= '0;
        end else begin
            r_div_go <= 1'b0;
            if (out_xfer) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        r_red_total <= r_red_total + TOTAL_BITS'(red_in);
                        r_ir_total  <= r_ir_total + TOTAL_BITS'(ir_in);
                        r_count     <= n_count;
                        if (red_in < r_red_low)  r_red_low  <= red_in;
                        if (red_in > r_red_high) r_red_high <= red_in;
                        if (ir_in < r_ir_low)    r_ir_low   <= ir_in;
                        if (ir_in > r_ir_high)   r_ir_high  <= ir_in;
                        if (closes) begin
                            r_state  <= S_DIV_IR;
                            r_div_go <= 1'b1;
                        end
                    end
                end
                S_DIV_IR: begin
                    if (div_rsp.done) begin
                        r_ir_mean <= quot;
                        r_state   <= S_DIV_RED;
                        r_div_go  <= 1'b1;
                    end
                end
                S_DIV_RED: begin
                    if (div_rsp.done) begin
                        r_red_mean <= quot;
                        r_state    <= S_WEAR;
                    end
                end
                S_WEAR: begin
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (load_out) begin
                        r_out_valid <= 1'b1;
                        r_out_data  <= {(OUT_BITS - OUT_USED)'(0), phase, red_swing,
                                        r_red_mean, ir_swing, r_ir_mean};
                        r_count     <= '0;
                        r_red_total <= '0;
                        r_ir_total  <= '0;
                        r_red_low   <= '1;
                        r_red_high  <= '0;
                        r_ir_low    <= '1;
                        r_ir_high   <= '0;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // configuration registers
    assign reg_idx = paddr[ADDR_BITS-1:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ir_mean_threshold  <= '0;
            r_cfg.red_mean_threshold <= '0;
            r_cfg.window_length      <= WINDOW_RESET;
            r_cfg.confirm_windows    <= CONFIRM_RESET;
            r_cfg.release_windows    <= RELEASE_RESET;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_IR_THR:  r_cfg.ir_mean_threshold  <= pwdata[SAMPLE_BITS-1:0];
                REG_RED_THR: r_cfg.red_mean_threshold <= pwdata[SAMPLE_BITS-1:0];
                REG_WINDOW:  r_cfg.window_length      <= pwdata[COUNT_BITS-1:0];
                REG_CONFIRM: r_cfg.confirm_windows    <= pwdata[RUN_BITS-1:0];
                REG_RELEASE: r_cfg.release_windows    <= pwdata[RUN_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_IR_THR:  prdata = APB_BITS'(r_cfg.ir_mean_threshold);
            REG_RED_THR: prdata = APB_BITS'(r_cfg.red_mean_threshold);
            REG_WINDOW:  prdata = APB_BITS'(r_cfg.window_length);
            REG_CONFIRM: prdata = APB_BITS'(r_cfg.confirm_windows);
            REG_RELEASE: prdata = APB_BITS'(r_cfg.release_windows);
            default:     prdata = '0;
        endcase
    end

    assign pready        = 1'b1;
    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

// ===== hw/rtl/owd_checker.sv =====
// ----------------------------------------------------------------------------
// owd_checker
// Port-level assertions for the optical wear detector, bound to the top level.
// ----------------------------------------------------------------------------
module owd_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         s_axis_tvalid,
    input logic                         s_axis_tready,
    input logic                         m_axis_tvalid,
    input logic                         m_axis_tready,
    input logic [owd_pkg::OUT_BITS-1:0] m_axis_tdata
);
    import owd_pkg::*;

    localparam int ST_LO = 4 * SAMPLE_BITS;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    a_out_data_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result changed while stalled");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[ST_LO+1:ST_LO] != 2'd3)
        else $error("invalid wear status");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid && s_axis_tready)
        else $error("not idle after reset");

    a_ready_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready && !s_axis_tvalid |=> s_axis_tready)
        else $error("input ready dropped without a transfer");

endmodule

bind optical_wear_detector owd_checker u_owd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// ===== tb/optical_wear_detector_test.sv =====
// ----------------------------------------------------------------------------
// optical_wear_detector_test
// Self-checking bench for the optical wear detector. Red/IR sample transfers
// go in on the input stream while an in-bench model tracks window sums,
// extremes and the wear state; every window-close result on the output
// stream is checked field by field. Register access is checked over APB,
// then directed cases cover sample extremes, single-sample and zero-length
// windows, wear entry and release, a shrunk window and the longest window;
// random phases with fresh settings and idle bursts on both streams follow.
// ----------------------------------------------------------------------------
module optical_wear_detector_test;
    import owd_pkg::*;

    localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = '1;
    localparam logic [2:0] REG_UNUSED   = 3'd5;
    localparam int         SETTLE_CYCLES = 80;
    localparam int         CYCLE_LIMIT   = 1000000;
    localparam int         RANDOM_ITEMS  = 800;

    typedef enum {
        MIX_WORN,
        MIX_IR_ONLY,
        MIX_RED_ONLY,
        MIX_LOW,
        MIX_NOISE
    } t_window_mix;

    typedef struct {
        logic [SAMPLE_BITS-1:0] ir_mean;
        logic [SAMPLE_BITS-1:0] ir_swing;
        logic [SAMPLE_BITS-1:0] red_mean;
        logic [SAMPLE_BITS-1:0] red_swing;
        t_phase                 status;
    } t_window_stats;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    // [17:0] red_sample, [35:18] ir_sample
    logic [IN_BITS-1:0] s_axis_tdata = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    // [17:0] ir_mean, [35:18] ir_swing, [53:36] red_mean, [71:54] red_swing,
    // [73:72] wear_status
    logic [OUT_BITS-1:0] m_axis_tdata;
    logic                 psel    = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite  = 1'b0;
    logic [ADDR_BITS-1:0] paddr   = '0;
    logic [APB_BITS-1:0]  pwdata  = '0;
    logic [APB_BITS-1:0]  prdata;
    logic                 pready;

    // model copy of the registers
    logic [SAMPLE_BITS-1:0] ir_thr, red_thr;
    logic [COUNT_BITS-1:0]  window_len;
    logic [RUN_BITS-1:0]    confirm_len, release_len;

    // model copy of the window and wear state
    logic [TOTAL_BITS-1:0]  red_sum, ir_sum;
    logic [SAMPLE_BITS-1:0] red_min, red_max, ir_min, ir_max;
    logic [COUNT_BITS-1:0]  fill;
    t_phase                 wear;
    logic [RUN_BITS-1:0]    confirm_cnt, release_cnt;

    t_window_stats window_stats_due[$];
    int  mismatches = 0;
    int  cycles     = 0;
    int  stall_left = 0;
    bit  idle_on    = 1'b0;

    optical_wear_detector dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    function automatic void clear_window();
        red_sum = '0;
        ir_sum  = '0;
        red_min = SAMPLE_MAX;
        red_max = '0;
        ir_min  = SAMPLE_MAX;
        ir_max  = '0;
        fill    = '0;
    endfunction

    function automatic void reset_model();
        ir_thr      = '0;
        red_thr     = '0;
        window_len  = WINDOW_RESET;
        confirm_len = CONFIRM_RESET;
        release_len = RELEASE_RESET;
        clear_window();
        wear        = PHASE_UNCAL;
        confirm_cnt = '0;
        release_cnt = '0;
    endfunction

    function automatic void apply_register(logic [2:0] index, logic [APB_BITS-1:0] value);
        case (index)
            REG_IR_THR:  ir_thr      = value[SAMPLE_BITS-1:0];
            REG_RED_THR: red_thr     = value[SAMPLE_BITS-1:0];
            REG_WINDOW:  window_len  = value[COUNT_BITS-1:0];
            REG_CONFIRM: confirm_len = value[RUN_BITS-1:0];
            REG_RELEASE: release_len = value[RUN_BITS-1:0];
            default: ;
        endcase
    endfunction

    function automatic logic [APB_BITS-1:0] register_value(logic [2:0] index);
        case (index)
            REG_IR_THR:  return APB_BITS'(ir_thr);
            REG_RED_THR: return APB_BITS'(red_thr);
            REG_WINDOW:  return APB_BITS'(window_len);
            REG_CONFIRM: return APB_BITS'(confirm_len);
            REG_RELEASE: return APB_BITS'(release_len);
            default:     return '0;
        endcase
    endfunction

    function automatic void update_wear(logic [SAMPLE_BITS-1:0] ir_avg,
                                        logic [SAMPLE_BITS-1:0] red_avg);
        if (ir_thr == 0 || red_thr == 0) begin
            wear        = PHASE_UNCAL;
            confirm_cnt = '0;
            release_cnt = '0;
        end else if (ir_avg >= ir_thr && red_avg >= red_thr) begin
            release_cnt = '0;
            if (wear != PHASE_WORN) begin
                confirm_cnt = confirm_cnt + 1'b1;
                if (confirm_cnt >= confirm_len) begin
                    wear        = PHASE_WORN;
                    confirm_cnt = '0;
                end
            end
        end else begin
            confirm_cnt = '0;
            if (wear == PHASE_WORN) begin
                release_cnt = release_cnt + 1'b1;
                if (release_cnt >= release_len) begin
                    wear        = PHASE_NOT_WORN;
                    release_cnt = '0;
                end
            end else begin
                wear        = PHASE_NOT_WORN;
                release_cnt = '0;
            end
        end
    endfunction

    // fold one accepted sample into the window; queue the stats when it closes
    function automatic void absorb_sample(logic [SAMPLE_BITS-1:0] red,
                                          logic [SAMPLE_BITS-1:0] ir);
        t_window_stats         w;
        logic [TOTAL_BITS-1:0] q;
        red_sum = red_sum + TOTAL_BITS'(red);
        ir_sum  = ir_sum + TOTAL_BITS'(ir);
        if (red < red_min) red_min = red;
        if (red > red_max) red_max = red;
        if (ir < ir_min) ir_min = ir;
        if (ir > ir_max) ir_max = ir;
        fill = fill + 1'b1;
        if (fill != 0 && fill < window_len) return;
        if (fill == 0) begin
            w.ir_mean  = '0;
            w.red_mean = '0;
        end else begin
            q = ir_sum / TOTAL_BITS'(fill);
            w.ir_mean = q[SAMPLE_BITS-1:0];
            q = red_sum / TOTAL_BITS'(fill);
            w.red_mean = q[SAMPLE_BITS-1:0];
        end
        w.ir_swing  = ir_max - ir_min;
        w.red_swing = red_max - red_min;
        update_wear(w.ir_mean, w.red_mean);
        w.status = wear;
        window_stats_due.push_back(w);
        clear_window();
    endfunction

    task automatic compare_field(input string field, input logic [SAMPLE_BITS-1:0] want,
                                 input logic [SAMPLE_BITS-1:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
            mismatches++;
        end
    endtask

    // receiver stalls and result check
    always @(posedge i_clk) begin : result_side
        t_window_stats w;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (window_stats_due.size() == 0) begin
                $display("%0t: result expected none actual %h", $time, m_axis_tdata);
                mismatches++;
            end else begin
                w = window_stats_due.pop_front();
                compare_field("ir_mean", w.ir_mean, m_axis_tdata[17:0]);
                compare_field("ir_swing", w.ir_swing, m_axis_tdata[35:18]);
                compare_field("red_mean", w.red_mean, m_axis_tdata[53:36]);
                compare_field("red_swing", w.red_swing, m_axis_tdata[71:54]);
                compare_field("wear_status", SAMPLE_BITS'(w.status),
                              SAMPLE_BITS'(m_axis_tdata[73:72]));
            end
        end
        if (stall_left > 0) begin
            stall_left    <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            stall_left    <= $urandom_range(0, 10);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    task automatic apb_write(input logic [2:0] index, input logic [APB_BITS-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_BITS'({index, 2'b00});
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        apply_register(index, value);
        @(posedge i_clk);
    endtask

    task automatic apb_read_check(input logic [2:0] index);
        logic [APB_BITS-1:0] got;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_BITS'({index, 2'b00});
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        got = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (got !== register_value(index)) begin
            $display("%0t: register %0d expected %h actual %h", $time, index,
                     register_value(index), got);
            mismatches++;
        end
        @(posedge i_clk);
    endtask

    // tvalid stays high after a transfer so the next sample can follow back to back
    task automatic send_sample(input logic [SAMPLE_BITS-1:0] red,
                               input logic [SAMPLE_BITS-1:0] ir);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_BITS'({ir, red});
        do @(posedge i_clk); while (!s_axis_tready);
        absorb_sample(red, ir);
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (window_stats_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_all(input logic [APB_BITS-1:0] ir_t, input logic [APB_BITS-1:0] red_t,
                             input logic [APB_BITS-1:0] len, input logic [APB_BITS-1:0] conf,
                             input logic [APB_BITS-1:0] rel);
        apb_write(REG_IR_THR, ir_t);
        apb_write(REG_RED_THR, red_t);
        apb_write(REG_WINDOW, len);
        apb_write(REG_CONFIRM, conf);
        apb_write(REG_RELEASE, rel);
    endtask

    task automatic test_registers();
        for (int i = REG_IR_THR; i <= REG_RELEASE; i++) apb_read_check(3'(i));
        write_all(32'hFFFF_FFFF, 32'hFFFC_0000, 32'hFFFF_FBFF, 32'hFFFF_FFF0, 32'hFFFF_FFFF);
        apb_write(REG_UNUSED, $urandom);
        for (int i = REG_IR_THR; i <= REG_RELEASE; i++) apb_read_check(3'(i));
    endtask

    task automatic test_sample_extremes();
        write_all(0, 0, 4, 3, 2);
        send_sample(0, SAMPLE_MAX);
        send_sample(SAMPLE_MAX, 0);
        send_sample(SAMPLE_MAX, SAMPLE_MAX);
        send_sample(0, 0);
        drain_results();
        apb_write(REG_WINDOW, 1);
        send_sample(SAMPLE_MAX, 0);
        send_sample(0, SAMPLE_MAX);
        drain_results();
        apb_write(REG_WINDOW, 0);
        send_sample(18'h2AAAA, 18'h15555);
        send_sample(18'h15555, 18'h2AAAA);
        drain_results();
    endtask

    task automatic test_wear_transitions();
        write_all(1000, 2000, 1, 2, 2);
        send_sample(500, 500);
        send_sample(2000, 1000);
        send_sample(2000, 1000);
        send_sample(1999, 5000);
        send_sample(3000, 3000);
        send_sample(10, 10);
        send_sample(9000, 999);
        drain_results();
        apb_write(REG_CONFIRM, 0);
        apb_write(REG_RELEASE, 0);
        send_sample(2500, 1500);
        send_sample(0, 0);
        drain_results();
        apb_write(REG_RED_THR, 0);
        send_sample(SAMPLE_MAX, SAMPLE_MAX);
        drain_results();
    endtask

    task automatic test_window_shrink();
        apb_write(REG_RED_THR, 300);
        apb_write(REG_WINDOW, 8);
        repeat (5) send_sample(18'($urandom), 18'($urandom));
        drain_results();
        apb_write(REG_WINDOW, 3);
        send_sample(18'($urandom), 18'($urandom));
        drain_results();
    endtask

    task automatic test_longest_window();
        write_all(1, SAMPLE_MAX, 1023, 1, 1);
        send_sample(0, 0);
        repeat (1022) send_sample(SAMPLE_MAX, SAMPLE_MAX);
        drain_results();
    endtask

    function automatic logic [SAMPLE_BITS-1:0] level_sample(bit high,
                                                           logic [SAMPLE_BITS-1:0] thr);
        if (thr == 0) return SAMPLE_BITS'($urandom);
        if (high) return SAMPLE_BITS'($urandom_range(SAMPLE_MAX, thr));
        return SAMPLE_BITS'($urandom_range(thr - 1, 0));
    endfunction

    function automatic logic [APB_BITS-1:0] pick_threshold();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 0;
        if (r == 1) return SAMPLE_MAX;
        return $urandom_range(SAMPLE_MAX, 1);
    endfunction

    function automatic t_window_mix pick_mix();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return MIX_WORN;
        if (r < 50) return MIX_IR_ONLY;
        if (r < 60) return MIX_RED_ONLY;
        if (r < 85) return MIX_LOW;
        return MIX_NOISE;
    endfunction

    task automatic test_random_phases();
        int          sent;
        int          r;
        int          mix_left;
        t_window_mix mix;
        logic [APB_BITS-1:0] len;
        sent     = 0;
        mix_left = 0;
        mix      = MIX_WORN;
        while (sent < RANDOM_ITEMS) begin
            r = $urandom_range(0, 19);
            if (r == 0) len = 0;
            else if (r < 4) len = $urandom_range(40, 7);
            else len = $urandom_range(6, 1);
            write_all(pick_threshold(), pick_threshold(), len,
                      $urandom_range(15, 0), $urandom_range(15, 0));
            idle_on = (sent < RANDOM_ITEMS * 3 / 4) && ($urandom_range(0, 3) != 0);
            repeat ($urandom_range(160, 40)) begin
                if (fill == 0) begin
                    if (mix_left == 0) begin
                        mix      = pick_mix();
                        mix_left = $urandom_range(18, 1);
                    end
                    mix_left--;
                end
                case (mix)
                    MIX_WORN:     send_sample(level_sample(1, red_thr), level_sample(1, ir_thr));
                    MIX_IR_ONLY:  send_sample(level_sample(0, red_thr), level_sample(1, ir_thr));
                    MIX_RED_ONLY: send_sample(level_sample(1, red_thr), level_sample(0, ir_thr));
                    MIX_LOW:      send_sample(level_sample(0, red_thr), level_sample(0, ir_thr));
                    default:      send_sample(SAMPLE_BITS'($urandom), SAMPLE_BITS'($urandom));
                endcase
                sent++;
            end
            drain_results();
        end
    endtask

    initial begin
        reset_model();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_registers();
        idle_on = 1'b1;
        test_sample_extremes();
        test_wear_transitions();
        test_window_shrink();
        test_longest_window();
        test_random_phases();
        idle_on = 1'b0;
        drain_results();
        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
